// ===== rtl/core/multi_slot_periodic_timer_macros.svh =====
// assertion macros for the periodic timer
`ifndef MULTI_SLOT_PERIODIC_TIMER_MACROS_SVH
`define MULTI_SLOT_PERIODIC_TIMER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MSPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MSPT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/mspt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspt_pkg
// shared types and constants of the periodic timer
// ----------------------------------------------------------------------------
package mspt_pkg;
	localparam int SLOTS_DEF = 16;
	localparam int TIME_BITS_DEF = 48;
	localparam int FIELD_W = 48;
	localparam int SLOT_W = 4;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_CFG = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_STOP = 2'd3;

	typedef struct packed {
		logic load;      // latch input item
		logic apply_cmd; // configure, start or stop
		logic scan_rd;   // read slot at scan index
		logic eval;      // evaluate read slot
		logic div_start;
		logic commit;    // write back slot, emit result if any
		logic marker;    // emit end marker
		logic scan_inc;
	} ctl_t;

	typedef struct packed {
		logic is_tick;
		logic scan_done;
		logic need_div;
		logic div_done;
		logic out_busy;
	} sts_t;
endpackage

// ===== rtl/core/mspt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspt_if
// valid/ready channel carrying a payload struct
// ----------------------------------------------------------------------------
interface mspt_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mspt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspt_div
// restoring divider, one quotient bit per cycle, remainder out
// ----------------------------------------------------------------------------
module mspt_div #(
	parameter int W = mspt_pkg::TIME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [W:0] trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
	assign rem = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/core/mspt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspt_dp
// slot table, scan evaluation, catch-up arithmetic and result register
// ----------------------------------------------------------------------------
module mspt_dp #(
	parameter int SLOTS = mspt_pkg::SLOTS_DEF,
	parameter int TIME_BITS = mspt_pkg::TIME_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mspt_pkg::ctl_t ctl,
	output mspt_pkg::sts_t sts,
	input  logic [1:0]     command,
	input  logic [3:0]     slot,
	input  logic [47:0]    interval,
	input  logic           repeating,
	input  logic           continuous,
	input  logic           system_clock,
	input  logic [47:0]    real_time,
	input  logic [47:0]    sim_time,
	input  logic [47:0]    real_delta,
	input  logic [47:0]    sim_delta,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           fired,
	output logic [3:0]     fired_slot,
	output logic [47:0]    fire_delta,
	output logic           last
);
	localparam int T = TIME_BITS;
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SW = $clog2(SLOTS + 1);
	localparam logic [T-1:0] TMAX = '1;

	function automatic logic [T-1:0] sat_in(input logic [47:0] v);
		logic [T-1:0] r;
		if (T >= 48) r = T'(v);
		else if ((v >> T) != 48'd0) r = TMAX;
		else r = v[T-1:0];
		return r;
	endfunction

	function automatic logic [T-1:0] sat_add(input logic [T-1:0] a, input logic [T-1:0] b);
		logic [T:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[T] ? TMAX : s[T-1:0];
	endfunction

	function automatic logic [47:0] to48(input logic [T-1:0] v);
		logic [47:0] r;
		if (T >= 48) r = v[47:0];
		else r = 48'(v);
		return r;
	endfunction

	// control flags in flops, times in a memory
	logic [SLOTS-1:0] act_q, rep_q, con_q, sys_q;
	logic [SLOTS-1:0] wr_q;
	logic [T-1:0] iv_mem [SLOTS];
	logic [T-1:0] nd_mem [SLOTS];

	logic [1:0] cmd_q;
	logic [3:0] slot_q;
	logic [T-1:0] iv_in_q, rt_q, st_q, rd_q, sd_q;
	logic rep_in_q, con_in_q, sys_in_q;
	logic [SW-1:0] idx_q;
	logic [IW-1:0] ridx_s1;
	logic [T-1:0] iv_s1, nd_s1;
	logic [T-1:0] t_q, iv_e_q, nd2_q, d_q;
	logic fire_e_q, upd_e_q, deact_e_q, div_q;
	logic [T-1:0] rem;
	logic div_done;
	logic [T-1:0] nd_new;
	logic [IW-1:0] cidx;
	logic [IW-1:0] raddr;
	logic slot_ok;

	assign cidx = IW'(slot_q);
	assign raddr = (cmd_q == mspt_pkg::CMD_TICK) ? idx_q[IW-1:0] : cidx;
	assign slot_ok = (SLOTS >= 16) ? 1'b1 : ({28'd0, slot_q} < 32'(SLOTS));

	mspt_div #(.W(T)) u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.num(t_q - nd2_q), .den(iv_e_q), .done(div_done), .rem(rem)
	);

	// first whole-interval step after the tick time
	assign nd_new = sat_add(t_q - rem, iv_e_q);

	assign sts.is_tick = (cmd_q == mspt_pkg::CMD_TICK);
	assign sts.scan_done = (idx_q == SW'(SLOTS));
	assign sts.need_div = div_q;
	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			slot_q <= slot;
			iv_in_q <= sat_in(interval);
			rep_in_q <= repeating;
			con_in_q <= continuous;
			sys_in_q <= system_clock;
			rt_q <= sat_in(real_time);
			st_q <= sat_in(sim_time);
			rd_q <= sat_in(real_delta);
			sd_q <= sat_in(sim_delta);
		end
		if (ctl.scan_rd) begin
			ridx_s1 <= raddr;
			iv_s1 <= wr_q[raddr] ? iv_mem[raddr] : '0;
			nd_s1 <= nd_mem[raddr];
		end
		if (ctl.apply_cmd && slot_ok) begin
			if (cmd_q == mspt_pkg::CMD_CFG) begin
				iv_mem[cidx] <= iv_in_q;
				nd_mem[cidx] <= (rep_in_q && !con_in_q) ?
					sat_add(iv_in_q, sys_in_q ? rt_q : st_q) : '0;
			end else if (cmd_q == mspt_pkg::CMD_START && !con_q[cidx]) begin
				// interval read here is the single-port read of the stored entry
				nd_mem[cidx] <= sat_add(iv_s1, sys_q[cidx] ? rt_q : st_q);
			end
		end
		if (ctl.eval) begin
			t_q <= sys_q[ridx_s1] ? rt_q : st_q;
			iv_e_q <= iv_s1;
			nd2_q <= sat_add(nd_s1, iv_s1);
		end
		if (ctl.commit && upd_e_q)
			nd_mem[ridx_s1] <= div_q ? nd_new : nd2_q;
	end

	// time for the evaluation decision, combinational in the eval cycle
	logic [T-1:0] tcur;
	always_comb tcur = sys_q[ridx_s1] ? rt_q : st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			rep_q <= '0;
			con_q <= '0;
			sys_q <= '0;
			wr_q <= '0;
			idx_q <= '0;
			fire_e_q <= 1'b0;
			upd_e_q <= 1'b0;
			deact_e_q <= 1'b0;
			div_q <= 1'b0;
			d_q <= '0;
			out_valid <= 1'b0;
			fired <= 1'b0;
			fired_slot <= '0;
			fire_delta <= '0;
			last <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (ctl.load) idx_q <= '0;
			if (ctl.scan_inc) idx_q <= idx_q + 1'b1;
			if (ctl.apply_cmd && slot_ok) begin
				case (cmd_q)
					mspt_pkg::CMD_CFG: begin
						rep_q[cidx] <= rep_in_q;
						con_q[cidx] <= con_in_q;
						sys_q[cidx] <= sys_in_q;
						act_q[cidx] <= rep_in_q;
						wr_q[cidx] <= 1'b1;
					end
					mspt_pkg::CMD_START: act_q[cidx] <= 1'b1;
					mspt_pkg::CMD_STOP: act_q[cidx] <= 1'b0;
					default: ;
				endcase
			end
			if (ctl.eval) begin
				if (!act_q[ridx_s1]) begin
					fire_e_q <= 1'b0;
					upd_e_q <= 1'b0;
					deact_e_q <= 1'b0;
					div_q <= 1'b0;
				end else if (con_q[ridx_s1]) begin
					fire_e_q <= 1'b1;
					upd_e_q <= 1'b0;
					deact_e_q <= !rep_q[ridx_s1];
					div_q <= 1'b0;
					d_q <= sys_q[ridx_s1] ? rd_q : sd_q;
				end else if (nd_s1 > tcur) begin
					fire_e_q <= 1'b0;
					upd_e_q <= 1'b0;
					deact_e_q <= 1'b0;
					div_q <= 1'b0;
				end else begin
					fire_e_q <= 1'b1;
					d_q <= sat_add(iv_s1, tcur - nd_s1);
					deact_e_q <= !rep_q[ridx_s1];
					upd_e_q <= rep_q[ridx_s1];
					div_q <= rep_q[ridx_s1] && (iv_s1 != '0) &&
						(sat_add(nd_s1, iv_s1) <= tcur);
				end
			end
			if (ctl.commit) begin
				if (deact_e_q) act_q[ridx_s1] <= 1'b0;
				if (fire_e_q) begin
					out_valid <= 1'b1;
					fired <= 1'b1;
					fired_slot <= 4'(ridx_s1);
					fire_delta <= to48(d_q);
					last <= 1'b0;
				end
			end
			if (ctl.marker) begin
				out_valid <= 1'b1;
				fired <= 1'b0;
				fired_slot <= '0;
				fire_delta <= '0;
				last <= 1'b1;
			end
		end
	end
endmodule

// ===== rtl/core/mspt_ctrl.sv =====
`timescale 1ns / 1ps
`include "multi_slot_periodic_timer_macros.svh"
// ----------------------------------------------------------------------------
// mspt_ctrl
// sequencer for commands and the per-tick slot scan
// ----------------------------------------------------------------------------
module mspt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mspt_pkg::sts_t sts,
	output mspt_pkg::ctl_t ctl
);
	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DECODE = 8'b0000_0010,
		ST_READ   = 8'b0000_0100,
		ST_EVAL   = 8'b0000_1000,
		ST_DIV    = 8'b0001_0000,
		ST_DWAIT  = 8'b0010_0000,
		ST_COMMIT = 8'b0100_0000,
		ST_MARK   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				// read the addressed entry for start, else begin scan
				ctl.scan_rd = 1'b1;
				state_d = sts.is_tick ? ST_EVAL : ST_READ;
			end
			ST_READ: begin
				if (!sts.is_tick) begin
					ctl.apply_cmd = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.scan_done) begin
					state_d = ST_MARK;
				end else begin
					ctl.scan_rd = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				ctl.eval = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.need_div) begin
					ctl.div_start = 1'b1;
					state_d = ST_DWAIT;
				end else begin
					state_d = ST_COMMIT;
				end
			end
			ST_DWAIT: if (sts.div_done) state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (!sts.out_busy) begin
					ctl.commit = 1'b1;
					ctl.scan_inc = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_MARK: begin
				if (!sts.out_busy) begin
					ctl.marker = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	`MSPT_ASSERT_IMPL(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`MSPT_ASSERT_NEXT(a_load_dec, clk, arst_n, ctl.load, state_q == ST_DECODE)
	`MSPT_ASSERT_NEXT(a_div_wait, clk, arst_n, ctl.div_start, state_q == ST_DWAIT)
	`MSPT_ASSERT_IMPL(a_no_emit_busy, clk, arst_n, ctl.commit || ctl.marker, !sts.out_busy)
endmodule

// ===== rtl/core/multi_slot_periodic_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer
// table of periodic timer slots with command port and tick scan
//
// channel   dir  payload
// cmd_in    in   command, slot, interval, mode bits, times, deltas
// res_out   out  fired, fired_slot, fire_delta, last
//
// configure/start/stop pass through decode and read before the next transfer
// a tick reads, evaluates and commits each slot in turn, plus a catch-up divide where needed
// output stalls hold the scan at the next emit
// reset clears the flags of all slots immediately, no clearing pass
// ----------------------------------------------------------------------------
module multi_slot_periodic_timer #(
	parameter int SLOTS = mspt_pkg::SLOTS_DEF,
	parameter int TIME_BITS = mspt_pkg::TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mspt_if.sink   cmd_in,
	mspt_if.source res_out
);
	mspt_pkg::ctl_t ctl;
	mspt_pkg::sts_t sts;

	mspt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(cmd_in.valid), .in_ready(cmd_in.ready),
		.sts(sts), .ctl(ctl)
	);

	mspt_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.command(cmd_in.data.command), .slot(cmd_in.data.slot),
		.interval(cmd_in.data.interval), .repeating(cmd_in.data.repeating),
		.continuous(cmd_in.data.continuous), .system_clock(cmd_in.data.system_clock),
		.real_time(cmd_in.data.real_time), .sim_time(cmd_in.data.sim_time),
		.real_delta(cmd_in.data.real_delta), .sim_delta(cmd_in.data.sim_delta),
		.out_valid(res_out.valid), .out_ready(res_out.ready),
		.fired(res_out.data.fired), .fired_slot(res_out.data.fired_slot),
		.fire_delta(res_out.data.fire_delta), .last(res_out.data.last)
	);
endmodule
